// File: rtl/lz77_block_decompressor_defines.svh
// Assertion macros used by the LZ77 block decompressor datapath.
`ifndef LZ77_BLOCK_DECOMPRESSOR_DEFINES_SVH
`define LZ77_BLOCK_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZ77BD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LZ77BD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lz77bd_pkg.sv
// Package: constants and controller/datapath types of the LZ77 block decompressor.
`default_nettype none

package lz77bd_pkg;

    localparam int HISTORY_BYTES_DEF = 4096;
    localparam int BYTE_W            = 8;
    localparam int MAX_DIST          = 4096;
    localparam int PROD_W            = 13;
    localparam int DIST_W            = 12;
    localparam int LEN_SHIFT         = 12;
    localparam int MIN_MATCH         = 3;
    localparam int LEN_W             = 5;
    localparam int POS_W             = 4;

    localparam logic [DIST_W-1:0] DIST_MASK      = 12'hFFF;
    localparam logic [POS_W-1:0]  FLAG_POS_EMPTY = 4'd8;

    typedef struct packed {
        logic load_flags;
        logic adv_flag;
        logic take_low;
        logic clear_pending;
        logic emit_literal;
        logic emit_marker;
        logic start_copy;
        logic issue;
        logic restart_parse;
        logic restart_ring;
    } t_dp_cmd;

    typedef struct packed {
        logic pair_pending;
        logic need_ctrl;
        logic flag_bit;
        logic ref_ok;
        logic in_last;
        logic s1_valid;
        logic s1_adv;
        logic out_free;
        logic rem_one;
    } t_dp_status;

endpackage

`default_nettype wire

// File: rtl/lz77bd_intf.sv
// Interfaces: compressed-byte request channel and decompressed-byte result channel.
`default_nettype none

interface lz77bd_in_if;
    import lz77bd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              last_in_block;

    modport source (output valid, output in_byte, output last_in_block, input ready);
    modport sink   (input valid, input in_byte, input last_in_block, output ready);
endinterface

interface lz77bd_out_if;
    import lz77bd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last_of_run;
    logic              end_of_block;

    modport source (output valid, output out_byte, output byte_valid, output last_of_run,
                    output end_of_block, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input last_of_run,
                    input end_of_block, output ready);
endinterface

`default_nettype wire

// File: rtl/lz77_block_decompressor.sv
// Top level of the LZ77 block decompressor: controller, datapath and channel hookup.
//
// Usage:
//   i_in  : compressed bytes of one block, one request per byte, with
//           last_in_block set on the final byte of the block.
//   o_out : decompressed bytes, one per result; byte_valid 0 marks an
//           end-only result, last_of_run closes the results of one request,
//           end_of_block closes the block.
// Timing:
//   A literal appears on o_out the cycle after its request is taken; a
//   control byte, a low reference byte or a reference that reaches too far
//   back gives no result (unless it ends the block).
//   A back-reference of length L (3..18) is read from the history RAM into
//   the copy stage and then moved to the result register, one byte a cycle
//   while o_out takes them, the pace of the single read port of the history
//   RAM; the next request is taken only once the copy stage is empty.
// Reset (synchronous, active low) returns the parser and ring pointers to
//   the start of a block; the history RAM is not cleared and needs no pass.
// When o_out.ready is low, the result register holds and the copy stalls in
//   place; no request is taken until the pending result can move.
`default_nettype none

module lz77_block_decompressor #(
    parameter int HISTORY_BYTES = lz77bd_pkg::HISTORY_BYTES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lz77bd_in_if.sink   i_in,
    lz77bd_out_if.source o_out
);
    import lz77bd_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    lz77bd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(i_in.ready),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd)
    );

    lz77bd_dp #(
        .HISTORY_BYTES(HISTORY_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_byte     (i_in.in_byte),
        .i_in_last     (i_in.last_in_block),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_out_byte    (o_out.out_byte),
        .o_byte_valid  (o_out.byte_valid),
        .o_last_of_run (o_out.last_of_run),
        .o_end_of_block(o_out.end_of_block)
    );

endmodule

`default_nettype wire

// File: rtl/lz77bd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lz77bd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read-first: a same-address write is not seen here
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/lz77bd_ctrl.sv
// Controller: request parsing decisions and the back-reference copy sequencer.
`default_nettype none

module lz77bd_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire lz77bd_pkg::t_dp_status i_status,
    output lz77bd_pkg::t_dp_cmd         o_cmd
);
    import lz77bd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_COPY = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        unique case (r_state)
            ST_IDLE: begin
                // take a request only when the copy stage is empty and a result slot is free
                o_in_ready = !i_status.s1_valid && i_status.out_free;
                if (i_in_valid && o_in_ready) begin
                    if (i_status.pair_pending) begin
                        o_cmd.clear_pending = 1'b1;
                        if (i_status.ref_ok) begin
                            o_cmd.start_copy = 1'b1;
                            n_state          = ST_COPY;
                        end else if (i_status.in_last) begin
                            o_cmd.emit_marker = 1'b1;
                        end
                    end else if (i_status.need_ctrl) begin
                        o_cmd.load_flags  = 1'b1;
                        o_cmd.emit_marker = i_status.in_last;
                    end else begin
                        o_cmd.adv_flag = 1'b1;
                        if (i_status.flag_bit) begin
                            o_cmd.take_low    = 1'b1;
                            o_cmd.emit_marker = i_status.in_last;
                        end else begin
                            o_cmd.emit_literal = 1'b1;
                        end
                    end
                    if (i_status.in_last) begin
                        o_cmd.restart_parse = 1'b1;
                        // a copy clears the ring pointers after its final byte
                        o_cmd.restart_ring  = !o_cmd.start_copy;
                    end
                end
            end
            ST_COPY: begin
                o_cmd.issue = !i_status.s1_valid || i_status.s1_adv;
                if (o_cmd.issue && i_status.rem_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lz77bd_dp.sv
// Datapath: flag parsing registers, history ring, copy stage and result register.
`default_nettype none
`include "lz77_block_decompressor_defines.svh"

module lz77bd_dp #(
    parameter int HISTORY_BYTES = lz77bd_pkg::HISTORY_BYTES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [lz77bd_pkg::BYTE_W-1:0]  i_in_byte,
    input  wire logic                           i_in_last,
    input  wire lz77bd_pkg::t_dp_cmd            i_cmd,
    output lz77bd_pkg::t_dp_status              o_status,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [lz77bd_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                                o_byte_valid,
    output logic                                o_last_of_run,
    output logic                                o_end_of_block
);
    import lz77bd_pkg::*;

    localparam int PW = $clog2(HISTORY_BYTES);
    localparam logic [PW-1:0] PTR_LAST = PW'(HISTORY_BYTES - 1);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    // parsing state
    logic [BYTE_W-1:0] r_flags;
    logic [POS_W-1:0]  r_pos;
    logic [BYTE_W-1:0] r_low;
    logic              r_pending;

    // ring pointers and copy sequencer
    logic [PW-1:0]     r_wp;
    logic [PROD_W-1:0] r_prod;
    logic [PW-1:0]     r_rp;
    logic [LEN_W-1:0]  r_rem;
    logic              r_blk_last;

    // copy stage (RAM output) with same-address forward
    logic              r_s1_v;
    logic              r_s1_fin;
    logic              r_fwd;
    logic [BYTE_W-1:0] r_fwd_data;
    logic [BYTE_W-1:0] ram_q;
    logic [BYTE_W-1:0] s1_data;
    logic              s1_adv;

    logic [2*BYTE_W-1:0] word;
    logic [PROD_W-1:0]   ref_dist;
    logic [LEN_W-1:0]    len;
    logic [PW:0]         src_diff;
    logic [PW:0]         src_wrap;
    logic [PW-1:0]       src;
    logic                ram_we;
    logic [BYTE_W-1:0]   ram_wdata;
    logic                out_load;
    logic                ring_clear;

    assign word     = {i_in_byte, r_low};
    assign ref_dist = {1'b0, word[DIST_W-1:0] & DIST_MASK} + PROD_W'(1);
    assign len      = LEN_W'(word[2*BYTE_W-1:LEN_SHIFT]) + LEN_W'(MIN_MATCH);
    assign src_diff = {1'b0, r_wp} - (PW+1)'(ref_dist);
    assign src_wrap = src_diff + (PW+1)'(HISTORY_BYTES);
    assign src      = src_diff[PW] ? src_wrap[PW-1:0] : src_diff[PW-1:0];

    assign s1_data  = r_fwd ? r_fwd_data : ram_q;
    assign s1_adv   = r_s1_v && (!o_out_valid || i_out_ready);
    assign ram_we   = i_cmd.emit_literal || s1_adv;
    assign ram_wdata = i_cmd.emit_literal ? i_in_byte : s1_data;
    assign out_load = i_cmd.emit_literal || i_cmd.emit_marker || s1_adv;
    assign ring_clear = i_cmd.restart_ring || (s1_adv && r_s1_fin && r_blk_last);

    always_comb begin
        o_status.pair_pending = r_pending;
        o_status.need_ctrl    = r_pos[POS_W-1];
        o_status.flag_bit     = r_flags[r_pos[2:0]];
        o_status.ref_ok       = ref_dist <= r_prod;
        o_status.in_last      = i_in_last;
        o_status.s1_valid     = r_s1_v;
        o_status.s1_adv       = s1_adv;
        o_status.out_free     = !o_out_valid || i_out_ready;
        o_status.rem_one      = r_rem == LEN_W'(1);
    end

    lz77bd_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(HISTORY_BYTES)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wp),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.issue),
        .i_raddr(r_rp),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags   <= '0;
            r_pos     <= FLAG_POS_EMPTY;
            r_low     <= '0;
            r_pending <= 1'b0;
        end else if (i_cmd.restart_parse) begin
            r_flags   <= '0;
            r_pos     <= FLAG_POS_EMPTY;
            r_low     <= '0;
            r_pending <= 1'b0;
        end else begin
            if (i_cmd.load_flags) begin
                r_flags <= i_in_byte;
                r_pos   <= '0;
            end
            if (i_cmd.adv_flag) begin
                r_pos <= r_pos + POS_W'(1);
            end
            if (i_cmd.take_low) begin
                r_low     <= i_in_byte;
                r_pending <= 1'b1;
            end
            if (i_cmd.clear_pending) begin
                r_pending <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_prod <= '0;
        end else if (ring_clear) begin
            r_wp   <= '0;
            r_prod <= '0;
        end else if (ram_we) begin
            r_wp <= ptr_inc(r_wp);
            if (r_prod < PROD_W'(MAX_DIST)) begin
                r_prod <= r_prod + PROD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem      <= '0;
            r_blk_last <= 1'b0;
            r_s1_v     <= 1'b0;
        end else begin
            if (i_cmd.start_copy) begin
                r_rem      <= len;
                r_blk_last <= i_in_last;
            end else if (i_cmd.issue) begin
                r_rem <= r_rem - LEN_W'(1);
            end
            if (i_cmd.issue) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_copy) begin
            r_rp <= src;
        end else if (i_cmd.issue) begin
            r_rp <= ptr_inc(r_rp);
        end
        if (i_cmd.issue) begin
            r_s1_fin   <= r_rem == LEN_W'(1);
            // distance one: the byte being written now is the one being read
            r_fwd      <= s1_adv && (r_rp == r_wp);
            r_fwd_data <= s1_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_literal) begin
            o_out_byte     <= i_in_byte;
            o_byte_valid   <= 1'b1;
            o_last_of_run  <= 1'b1;
            o_end_of_block <= i_in_last;
        end else if (i_cmd.emit_marker) begin
            o_out_byte     <= '0;
            o_byte_valid   <= 1'b0;
            o_last_of_run  <= 1'b1;
            o_end_of_block <= 1'b1;
        end else if (s1_adv) begin
            o_out_byte     <= s1_data;
            o_byte_valid   <= 1'b1;
            o_last_of_run  <= r_s1_fin;
            o_end_of_block <= r_s1_fin && r_blk_last;
        end
    end

    `LZ77BD_ASSERT_IMP(a_lit_no_copy, i_clk, i_rst_n, i_cmd.emit_literal, !r_s1_v, "literal collides with a copy in flight")
    `LZ77BD_ASSERT_NXT(a_s1_hold, i_clk, i_rst_n, r_s1_v && !s1_adv, r_s1_v, "stalled copy byte lost")
    `LZ77BD_ASSERT_IMP(a_issue_rem, i_clk, i_rst_n, i_cmd.issue, r_rem != '0, "read issued past copy length")
    `LZ77BD_ASSERT_IMP(a_prod_sat, i_clk, i_rst_n, 1'b1, r_prod <= PROD_W'(MAX_DIST), "produced count over limit")

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// Testbench for the LZ77 block decompressor: directed and random blocks checked against an inline decoder.
module tb;
    import lz77bd_pkg::*;

    localparam int RING_BYTES    = 4096;
    localparam int RANDOM_ITEMS  = 55;
    localparam int LONG_SPAN     = 36;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 40;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 2000000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } comp_byte_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              data_ok;
        logic              run_end;
        logic              blk_end;
    } plain_byte_t;

    logic i_clk;
    logic i_rst_n = 1'b0;

    lz77bd_in_if  in_if();
    lz77bd_out_if out_if();

    lz77_block_decompressor DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic              req_valid = 1'b0;
    logic [BYTE_W-1:0] req_byte  = '0;
    logic              req_last  = 1'b0;
    logic              rsp_ready = 1'b0;
    logic              req_taken = 1'b0;

    assign in_if.valid         = req_valid;
    assign in_if.in_byte       = req_byte;
    assign in_if.last_in_block = req_last;
    assign out_if.ready        = rsp_ready;

    comp_byte_t  compressed_q[$];
    plain_byte_t decoded_q[$];

    int cycle_cnt   = 0;
    int err_cnt     = 0;
    int sent_cnt    = 0;
    int queued_cnt  = 0;
    int blocks_made = 0;
    int result_cnt  = 0;
    int marker_cnt  = 0;
    int long_len    = 0;
    int send_gap    = 0;
    int recv_gap    = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    // decoder state
    logic [BYTE_W-1:0] ring [RING_BYTES];
    logic [DIST_W-1:0] wr_ptr    = '0;
    logic [PROD_W-1:0] made_cnt  = '0;
    logic [BYTE_W-1:0] flags     = '0;
    logic [POS_W-1:0]  flag_idx  = FLAG_POS_EMPTY;
    logic [BYTE_W-1:0] word_lo   = '0;
    logic              word_wait = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones; one stretch in four has none at all.
    function automatic int idle_len(input int busy_pct);
        int roll;
        roll = $urandom_range(99);
        if (cycle_cnt[10:9] == 2'b11 || roll < busy_pct) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_cnt, what);
        err_cnt++;
    endtask

    task automatic keep_byte(input logic [BYTE_W-1:0] v);
        ring[wr_ptr] = v;
        wr_ptr = wr_ptr + 1'b1;
        if (made_cnt < MAX_DIST) made_cnt = made_cnt + 1'b1;
        decoded_q.push_back('{data: v, data_ok: 1'b1, run_end: 1'b0, blk_end: 1'b0});
    endtask

    task automatic decode_request(input comp_byte_t req);
        logic [15:0]       word;
        logic [DIST_W-1:0] back;
        int                ref_dist;
        int                len;
        int                n;
        n = 0;
        if (word_wait) begin
            word = {req.data, word_lo};
            ref_dist = int'(word[DIST_W-1:0]) + 1;
            len  = int'(word[15:LEN_SHIFT]) + MIN_MATCH;
            word_wait = 1'b0;
            // a reference past the bytes of this block is consumed silently
            if (ref_dist <= int'(made_cnt)) begin
                back = DIST_W'(ref_dist);
                for (int k = 0; k < len; k++) begin
                    keep_byte(ring[wr_ptr - back]);
                    n++;
                end
            end
        end else if (flag_idx >= FLAG_POS_EMPTY) begin
            flags    = req.data;
            flag_idx = '0;
        end else begin
            if (flags[flag_idx[2:0]]) begin
                word_lo   = req.data;
                word_wait = 1'b1;
            end else begin
                keep_byte(req.data);
                n++;
            end
            flag_idx = flag_idx + 1'b1;
        end

        if (req.last && n == 0) begin
            decoded_q.push_back('{data: '0, data_ok: 1'b0, run_end: 1'b0, blk_end: 1'b0});
            n++;
        end
        if (n > 0) begin
            decoded_q[decoded_q.size() - 1].run_end = 1'b1;
            decoded_q[decoded_q.size() - 1].blk_end = req.last;
        end
        if (req.last) begin
            wr_ptr    = '0;
            made_cnt  = '0;
            flags     = '0;
            flag_idx  = FLAG_POS_EMPTY;
            word_lo   = '0;
            word_wait = 1'b0;
        end
    endtask

    task automatic check_result();
        plain_byte_t want;
        if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %h valid %b",
                                      out_if.out_byte, out_if.byte_valid));
            return;
        end
        want = decoded_q.pop_front();
        result_cnt++;
        if (!want.data_ok) marker_cnt++;
        if (out_if.out_byte !== want.data)
            report_mismatch($sformatf("out_byte %h, want %h", out_if.out_byte, want.data));
        if (out_if.byte_valid !== want.data_ok)
            report_mismatch($sformatf("byte_valid %b, want %b", out_if.byte_valid, want.data_ok));
        if (out_if.last_of_run !== want.run_end)
            report_mismatch($sformatf("last_of_run %b, want %b", out_if.last_of_run, want.run_end));
        if (out_if.end_of_block !== want.blk_end)
            report_mismatch($sformatf("end_of_block %b, want %b", out_if.end_of_block,
                                      want.blk_end));
    endtask

    task automatic add_byte(input logic [BYTE_W-1:0] data, input logic last);
        compressed_q.push_back('{data: data, last: last});
        queued_cnt++;
        if (last) blocks_made++;
    endtask

    // Build one well-formed block of about span bytes; it may end on a control
    // byte or cut a reference word in half.
    task automatic gen_block(input int span, input bit long_run);
        logic [BYTE_W-1:0] ctrl;
        logic [15:0]       word;
        int                made;
        int                ref_dist;
        int                len;
        int                roll;
        bit                done;
        made = 0;
        done = 1'b0;
        while (!done) begin
            if (long_run && $urandom_range(3) != 0) ctrl = 8'hFF;
            else ctrl = 8'($urandom);
            if (span <= 1) begin
                add_byte(ctrl, 1'b1);
                done = 1'b1;
            end else begin
                add_byte(ctrl, 1'b0);
                span--;
                for (int f = 0; f < 8 && !done; f++) begin
                    if (!ctrl[f]) begin
                        span--;
                        add_byte(8'($urandom), span <= 0);
                        done = (span <= 0);
                        made = (made < MAX_DIST) ? made + 1 : made;
                    end else if (span == 1) begin
                        add_byte(8'($urandom), 1'b1);
                        done = 1'b1;
                    end else begin
                        roll = $urandom_range(99);
                        len  = long_run ? 18 : $urandom_range(MIN_MATCH, 18);
                        if (made == 0 || roll < 10) ref_dist = $urandom_range(1, MAX_DIST);
                        else if (roll < 30) ref_dist = made;
                        else if (roll < 55) ref_dist = $urandom_range(1, (made < 4) ? made : 4);
                        else ref_dist = $urandom_range(1, made);
                        word = {4'(len - MIN_MATCH), 12'(ref_dist - 1)};
                        add_byte(word[7:0], 1'b0);
                        span -= 2;
                        add_byte(word[15:8], span <= 0);
                        done = (span <= 0);
                        if (ref_dist <= made) begin
                            made = (made + len > MAX_DIST) ? MAX_DIST : made + len;
                        end
                    end
                end
            end
        end
    endtask

    // sender: present the next compressed byte once the previous one is taken
    always @(negedge i_clk) begin
        comp_byte_t nxt;
        if (i_rst_n && (!req_valid || req_taken)) begin
            if (send_gap > 0) begin
                req_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end else if (compressed_q.size() > 0) begin
                nxt = compressed_q.pop_front();
                req_valid <= 1'b1;
                req_byte  <= nxt.data;
                req_last  <= nxt.last;
                send_gap  <= idle_len(65);
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off while the sender keeps offering requests
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && sent_cnt >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                rsp_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                rsp_ready <= 1'b0;
                recv_gap  <= recv_gap - 1;
            end else begin
                rsp_ready <= 1'b1;
                recv_gap  <= idle_len(75);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        req_taken <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) check_result();
            if (in_if.valid && in_if.ready) begin
                decode_request('{data: in_if.in_byte, last: in_if.last_in_block});
                sent_cnt <= sent_cnt + 1;
            end
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, decoded_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        // control byte that ends the block: end-only marker
        add_byte(8'h55, 1'b1);
        // literal, overlapping max-length copy, literal, reference too far back,
        // four literals, then a fresh control byte with two short copies
        add_byte(8'h0A, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h0F, 1'b0);
        add_byte(8'hA5, 1'b0);
        add_byte(8'h3C, 1'b0);
        add_byte(8'h81, 1'b0);
        add_byte(8'h42, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h14, 1'b0);
        add_byte(8'h00, 1'b1);
        // word cut off by the end of the block
        add_byte(8'h01, 1'b0);
        add_byte(8'h10, 1'b1);
        // reference with nothing produced yet, ending the block
        add_byte(8'h01, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b1);
        // single literal closing the block
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);

        while (queued_cnt < 24 + RANDOM_ITEMS) begin
            if ($urandom_range(99) < 15) begin
                int noise_len;
                noise_len = $urandom_range(1, 6);
                for (int k = 1; k <= noise_len; k++) add_byte(8'($urandom), k == noise_len);
            end else begin
                gen_block($urandom_range(1, 30), 1'b0);
            end
        end
        // long block made mostly of maximum-length copies
        long_len = queued_cnt;
        gen_block(LONG_SPAN, 1'b1);
        long_len = queued_cnt - long_len;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (compressed_q.size() != 0 || req_valid || decoded_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d compressed bytes in %0d blocks, %0d results (%0d end-only)",
                 sent_cnt, blocks_made, result_cnt, marker_cnt);
        $display("one %0d-byte block of long copies; receiver held off %0d cycles once",
                 long_len, HOLD_CYCLES);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/lz77bd_pkg.sv
rtl/lz77bd_intf.sv
rtl/lz77bd_ram.sv
rtl/lz77bd_ctrl.sv
rtl/lz77bd_dp.sv
rtl/lz77_block_decompressor.sv
bench/tb.sv
